// ===== design/fst_pkg.sv =====
// Package: shared types and constants for the format string tokenizer.
`timescale 1ns / 1ps
package fst_pkg;

  localparam int unsigned MaxArgsDefault = 16;
  localparam logic [7:0] DefaultFloatPrec = 8'd6;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    PH_LIT, PH_PCT, PH_IDX, PH_FLAGS, PH_WID, PH_DOT, PH_PREC, PH_LLOOP, PH_DEAD
  } phase_e;

  typedef enum logic [2:0] {
    K_LIT = 3'd0, K_PCT = 3'd1, K_SPEC = 3'd2, K_DONE = 3'd3, K_ERR = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    T_STR = 4'd0, T_BOOL = 4'd1, T_FLOAT = 4'd2, T_CHAR = 4'd3, T_SIGNED = 4'd4,
    T_UNSIGNED = 4'd5, T_HEX = 4'd6, T_PTR = 4'd7, T_WILD = 4'd8
  } spec_e;

  typedef enum logic [3:0] {
    E_REP_FLAG = 4'd0, E_DUP_IDX = 4'd1, E_MIXED = 4'd2, E_UNTERM = 4'd3,
    E_NO_PREC = 4'd4, E_CHAR_EXTRA = 4'd5, E_PREC_INT = 4'd6, E_BAD_L = 4'd7,
    E_BAD_TYPE = 4'd8, E_UNUSED = 4'd9, E_IDX_BIG = 4'd10
  } err_e;

  localparam logic [7:0] ChPct = 8'h25;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChOne = 8'h31;
  localparam logic [7:0] ChUpX = 8'h58;
  localparam logic [7:0] ChUpP = 8'h50;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  spec_type;
    logic        upper_case;
    logic [4:0]  arg_index;
    logic [2:0]  flag_bits;
    logic [7:0]  field_width;
    logic [7:0]  precision_value;
    logic        has_precision;
    logic [11:0] literal_length;
    logic [3:0]  error_code;
    logic        end_of_run;
  } token_t;

  // What the front end hands over per character: up to two tokens.
  typedef struct packed {
    logic   v0;
    token_t t0;
    logic   v1;
    token_t t1;
  } step_t;

  function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, c[3:0]};
    return (v > 12'd255) ? 8'hff : v[7:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== design/fst_front.sv =====
// Front end: per-character parser state machine producing up to two tokens.
`timescale 1ns / 1ps
module fst_front #(
  parameter int unsigned MaxArgs = fst_pkg::MaxArgsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     ch_i,
  input  logic           last_i,
  input  logic [7:0]     dflt_prec_i,
  output fst_pkg::step_t step_o
);
  localparam int unsigned CntW = $clog2(MaxArgs + 1);
  localparam int unsigned IdxW = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;

  fst_pkg::phase_e phase_q, phase_d;
  logic [7:0]   idx_q, idx_d;
  logic [2:0]   flag_q, flag_d;
  logic [7:0]   wid_q, wid_d;
  logic [8:0]   prec_q, prec_d;
  logic [2:0]   mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MaxArgs-1:0] used_q, used_d;
  logic [11:0]  run_q, run_d;

  // Combinational step evaluation; mirrors the per-character state update.
  always_comb begin
    fst_pkg::token_t tk;
    fst_pkg::token_t a0, a1;
    logic n0, n1;
    logic given;
    logic [7:0] pv;
    logic do_type, do_flags, do_rec;
    logic [7:0] c;
    logic [3:0] r_type;
    logic r_up;
    logic [2:0] r_fl;
    logic [7:0] r_w, r_p;
    logic r_hp;
    logic [2:0] f;
    logic found;
    logic [4:0] first_unused;
    logic [MaxArgs-1:0] need;

    c = ch_i;
    phase_d = phase_q; idx_d = idx_q; flag_d = flag_q; wid_d = wid_q;
    prec_d = prec_q; mode_d = mode_q; cnt_d = cnt_q; used_d = used_q; run_d = run_q;
    a0 = '0; a1 = '0; n0 = 1'b0; n1 = 1'b0;
    do_type = 1'b0; do_flags = 1'b0; do_rec = 1'b0;
    r_type = '0; r_up = 1'b0; r_fl = '0; r_w = '0; r_p = '0; r_hp = 1'b0;
    given = 1'b0; pv = '0; f = '0; found = 1'b0; first_unused = '0; need = '0;
    tk = '0;

    case (phase_q)
      fst_pkg::PH_LIT: begin
        if (c == fst_pkg::ChPct) begin
          if (run_q != 12'd0) begin
            tk = '0; tk.kind = fst_pkg::K_LIT; tk.literal_length = run_q;
            a0 = tk; n0 = 1'b1;
          end
          run_d = '0;
          phase_d = fst_pkg::PH_PCT;
        end else if (run_q != 12'hfff) begin
          run_d = run_q + 12'd1;
        end
      end
      fst_pkg::PH_PCT: begin
        if (c == fst_pkg::ChPct) begin
          tk = '0; tk.kind = fst_pkg::K_PCT; a0 = tk; n0 = 1'b1;
          phase_d = fst_pkg::PH_LIT;
        end else begin
          flag_d = '0; wid_d = '0; prec_d = 9'd256; mode_d[2] = 1'b0;
          if (c >= fst_pkg::ChOne && c <= fst_pkg::ChNine) begin
            idx_d = {4'd0, c[3:0]};
            phase_d = fst_pkg::PH_IDX;
          end else if (mode_q[0]) begin
            tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_MIXED;
            a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
          end else begin
            mode_d[1] = 1'b1;
            idx_d = 8'(cnt_q) + 8'd1;
            do_flags = 1'b1;
          end
        end
      end
      fst_pkg::PH_IDX: begin
        if (fst_pkg::is_digit(c)) begin
          idx_d = fst_pkg::sat_digit(idx_q, c);
        end else if (c == fst_pkg::ChPct || c == fst_pkg::ChDollar) begin
          if (mode_q[1]) begin
            tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_MIXED;
            a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
          end else begin
            mode_d[0] = 1'b1;
            if (c == fst_pkg::ChPct) begin
              do_rec = 1'b1; r_type = fst_pkg::T_WILD;
            end else begin
              phase_d = fst_pkg::PH_FLAGS;
            end
          end
        end else if (mode_q[0]) begin
          tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_MIXED;
          a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
        end else begin
          mode_d[1] = 1'b1; mode_d[2] = 1'b1;
          wid_d = idx_q;
          idx_d = 8'(cnt_q) + 8'd1;
          if (c == fst_pkg::ChDot) phase_d = fst_pkg::PH_DOT;
          else do_type = 1'b1;
        end
      end
      fst_pkg::PH_FLAGS: do_flags = 1'b1;
      fst_pkg::PH_WID: begin
        if (fst_pkg::is_digit(c)) wid_d = fst_pkg::sat_digit(wid_q, c);
        else if (c == fst_pkg::ChDot) phase_d = fst_pkg::PH_DOT;
        else do_type = 1'b1;
      end
      fst_pkg::PH_DOT: begin
        if (fst_pkg::is_digit(c)) begin
          prec_d = {5'd0, c[3:0]}; phase_d = fst_pkg::PH_PREC;
        end else begin
          tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_NO_PREC;
          a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
        end
      end
      fst_pkg::PH_PREC: begin
        if (fst_pkg::is_digit(c)) prec_d = {1'b0, fst_pkg::sat_digit(prec_q[7:0], c)};
        else do_type = 1'b1;
      end
      fst_pkg::PH_LLOOP: begin
        if (c == "l") begin
        end else if (c == "d" || c == "i" || c == "u") begin
          do_rec = 1'b1;
          r_type = (c == "u") ? fst_pkg::T_UNSIGNED : fst_pkg::T_SIGNED;
          r_fl = flag_q; r_w = wid_q;
        end else begin
          tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_BAD_L;
          a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
        end
      end
      default: phase_d = fst_pkg::PH_DEAD;
    endcase

    // Flags stage (flag_d already holds the cleared value when entered from '%').
    if (do_flags) begin
      phase_d = fst_pkg::PH_FLAGS;
      f = (c == fst_pkg::ChPlus) ? 3'b001 : (c == fst_pkg::ChMinus) ? 3'b010 :
          (c == fst_pkg::ChZero) ? 3'b100 : 3'b000;
      if (f != 3'b000) begin
        if ((flag_d & f) != 3'b000) begin
          tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_REP_FLAG;
          a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
        end else begin
          flag_d = flag_d | f;
        end
      end else if (fst_pkg::is_digit(c)) begin
        wid_d = {4'd0, c[3:0]}; phase_d = fst_pkg::PH_WID;
      end else if (c == fst_pkg::ChDot) begin
        phase_d = fst_pkg::PH_DOT;
      end else begin
        do_type = 1'b1;
      end
    end

    // Type character, using the values the fields hold at this point.
    if (do_type) begin
      given = prec_d != 9'd256;
      pv = given ? prec_d[7:0] : 8'd0;
      r_fl = flag_d; r_w = wid_d;
      case (c)
        "s": begin do_rec = 1'b1; r_type = fst_pkg::T_STR; r_p = pv; r_hp = given; end
        "b": begin do_rec = 1'b1; r_type = fst_pkg::T_BOOL; r_p = pv; r_hp = given; end
        "f": begin
          do_rec = 1'b1; r_type = fst_pkg::T_FLOAT;
          r_p = given ? pv : dflt_prec_i; r_hp = 1'b1;
        end
        "c": begin
          if (flag_d != 3'd0 || wid_d != 8'd0 || given) begin
            tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_CHAR_EXTRA;
            a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
          end else begin
            do_rec = 1'b1; r_type = fst_pkg::T_CHAR; r_fl = '0; r_w = '0;
          end
        end
        "l", "i", "d", "u", "x", "X", "p", "P": begin
          if (given) begin
            tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_PREC_INT;
            a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
          end else if (c == "l") begin
            phase_d = fst_pkg::PH_LLOOP;
          end else begin
            do_rec = 1'b1;
            r_up = (c == fst_pkg::ChUpX) || (c == fst_pkg::ChUpP);
            if (c == "u") r_type = fst_pkg::T_UNSIGNED;
            else if (c == "x" || c == "X") r_type = fst_pkg::T_HEX;
            else if (c == "p" || c == "P") r_type = fst_pkg::T_PTR;
            else r_type = fst_pkg::T_SIGNED;
          end
        end
        default: begin
          tk = '0; tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_BAD_TYPE;
          a0 = tk; n0 = 1'b1; phase_d = fst_pkg::PH_DEAD;
        end
      endcase
    end

    if (do_rec) begin
      tk = '0;
      if (idx_d == 8'd0 || 32'(idx_d) > MaxArgs) begin
        tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_IDX_BIG;
        phase_d = fst_pkg::PH_DEAD;
      end else begin
        if (32'(idx_d) > 32'(cnt_q)) cnt_d = CntW'(idx_d);
        if (used_q[IdxW'(idx_d - 8'd1)]) begin
          tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_DUP_IDX;
          tk.arg_index = 5'(idx_d);
          phase_d = fst_pkg::PH_DEAD;
        end else begin
          used_d[IdxW'(idx_d - 8'd1)] = 1'b1;
          tk.kind = fst_pkg::K_SPEC; tk.spec_type = r_type; tk.upper_case = r_up;
          tk.arg_index = 5'(idx_d); tk.flag_bits = r_fl; tk.field_width = r_w;
          tk.precision_value = r_p; tk.has_precision = r_hp;
          phase_d = fst_pkg::PH_LIT; run_d = '0;
        end
      end
      a0 = tk; n0 = 1'b1;
    end

    // End of string.
    if (last_i) begin
      tk = '0;
      if (phase_d != fst_pkg::PH_DEAD) begin
        if (phase_d != fst_pkg::PH_LIT) begin
          tk.kind = fst_pkg::K_ERR;
          case (phase_d)
            fst_pkg::PH_DOT:   tk.error_code = fst_pkg::E_NO_PREC;
            fst_pkg::PH_PREC:  tk.error_code = fst_pkg::E_BAD_TYPE;
            fst_pkg::PH_LLOOP: tk.error_code = fst_pkg::E_BAD_L;
            default:           tk.error_code = fst_pkg::E_UNTERM;
          endcase
          a1 = tk; n1 = 1'b1;
        end else begin
          if (run_d != 12'd0) begin
            a0.kind = fst_pkg::K_LIT; a0.literal_length = run_d; n0 = 1'b1;
          end
          for (int i = 0; i < MaxArgs; i++) begin
            need[i] = (32'(i) < 32'(cnt_d)) && !used_d[i];
          end
          for (int i = MaxArgs - 1; i >= 0; i--) begin
            if (need[i]) begin found = 1'b1; first_unused = 5'(i + 1); end
          end
          if (found) begin
            tk.kind = fst_pkg::K_ERR; tk.error_code = fst_pkg::E_UNUSED;
            tk.arg_index = first_unused;
          end else begin
            tk.kind = fst_pkg::K_DONE; tk.arg_index = 5'(cnt_d);
          end
          a1 = tk; n1 = 1'b1;
        end
      end
      phase_d = fst_pkg::PH_LIT; idx_d = '0; flag_d = '0; wid_d = '0;
      prec_d = 9'd256; mode_d = '0; cnt_d = '0; used_d = '0; run_d = '0;
    end

    // Compact: when only one token exists it sits in slot 0.
    if (!n0 && n1) begin
      a0 = a1; n0 = 1'b1; n1 = 1'b0;
    end
    if (n1) a1.end_of_run = 1'b1;
    else a0.end_of_run = 1'b1;
    step_o.v0 = n0; step_o.t0 = a0; step_o.v1 = n1; step_o.t1 = a1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fst_pkg::PH_LIT;
      idx_q <= '0; flag_q <= '0; wid_q <= '0; prec_q <= 9'd256; mode_q <= '0;
      cnt_q <= '0; used_q <= '0; run_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; idx_q <= idx_d; flag_q <= flag_d; wid_q <= wid_d;
      prec_q <= prec_d; mode_q <= mode_d; cnt_q <= cnt_d; used_q <= used_d;
      run_q <= run_d;
    end
  end
endmodule

// ===== design/fst_queue.sv =====
// Token queue between the parser and the result port; takes up to two per cycle.
`timescale 1ns / 1ps
module fst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fst_pkg::step_t  step_i,
  output logic            room_o,
  input  logic            pop_i,
  output logic            empty_o,
  output fst_pkg::token_t head_o
);
  localparam int unsigned Depth = fst_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);

  fst_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] rd_q, wr_q;
  logic [PtrW:0] cnt_q;
  logic do_pop;
  logic [1:0] n_push;

  assign empty_o = cnt_q == '0;
  assign head_o = mem_q[rd_q];
  assign room_o = 32'(cnt_q) <= Depth - 2;
  assign do_pop = pop_i && !empty_o;
  assign n_push = push_i ? ({1'b0, step_i.v0} + {1'b0, step_i.v1}) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.v0) mem_q[wr_q] <= step_i.t0;
    if (push_i && step_i.v1) mem_q[wr_q + PtrW'(1)] <= step_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_q + PtrW'(n_push);
      rd_q <= rd_q + PtrW'(do_pop);
      cnt_q <= cnt_q + (PtrW+1)'(n_push) - (PtrW+1)'(do_pop);
    end
  end
endmodule

// ===== design/format_string_tokenizer_core.sv =====
// Top level of the format string tokenizer.
`timescale 1ns / 1ps
// One character is taken per cycle while full is low; the parser updates its
// state in that cycle and writes zero, one or two tokens into a four-entry
// queue, which drives the result ports from the next cycle on. full rises when
// fewer than two free entries remain, so the input stalls while results are not
// popped, and also when characters that end a string keep causing two tokens
// each faster than one token per cycle is popped.
module format_string_tokenizer_core #(
  parameter int unsigned MaxArgs = fst_pkg::MaxArgsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [3:0]  spec_type_o,
  output logic        upper_case_o,
  output logic [4:0]  arg_index_o,
  output logic [2:0]  flag_bits_o,
  output logic [7:0]  field_width_o,
  output logic [7:0]  precision_value_o,
  output logic        has_precision_o,
  output logic [11:0] literal_length_o,
  output logic [3:0]  error_code_o,
  output logic        end_of_run_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  logic [7:0] dflt_q;
  logic room, step;
  fst_pkg::step_t st;
  fst_pkg::token_t head;

  assign full = !room;
  assign step = push && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dflt_q <= fst_pkg::DefaultFloatPrec;
    else if (cfg_we_i) dflt_q <= cfg_wdata_i;
  end

  fst_front #(.MaxArgs(MaxArgs)) u_front (
    .clk_i, .rst_ni, .step_i(step), .ch_i, .last_i, .dflt_prec_i(dflt_q), .step_o(st)
  );

  fst_queue u_queue (
    .clk_i, .rst_ni, .push_i(step), .step_i(st), .room_o(room),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  assign kind_o = head.kind;
  assign spec_type_o = head.spec_type;
  assign upper_case_o = head.upper_case;
  assign arg_index_o = head.arg_index;
  assign flag_bits_o = head.flag_bits;
  assign field_width_o = head.field_width;
  assign precision_value_o = head.precision_value;
  assign has_precision_o = head.has_precision;
  assign literal_length_o = head.literal_length;
  assign error_code_o = head.error_code;
  assign end_of_run_o = head.end_of_run;

  a_two_only_with_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.v1 |-> st.v0) else $error("second token without first");
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_i) |=> u_front.phase_q == fst_pkg::PH_LIT)
    else $error("string not closed");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> !$rose(u_queue.cnt_q > 3'd4)) else $error("queue overflow");
endmodule

// ===== tb/tb_format_string_tokenizer_core.sv =====
// Testbench: directed and random format strings, checked against a token predictor.
`timescale 1ns / 1ps
module tb_format_string_tokenizer_core;

  localparam int unsigned MaxArgs = 16;
  localparam longint CycleLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  ch_i = 8'd0;
  logic        last_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  spec_type_o;
  logic        upper_case_o;
  logic [4:0]  arg_index_o;
  logic [2:0]  flag_bits_o;
  logic [7:0]  field_width_o;
  logic [7:0]  precision_value_o;
  logic        has_precision_o;
  logic [11:0] literal_length_o;
  logic [3:0]  error_code_o;
  logic        end_of_run_o;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;

  format_string_tokenizer_core #(.MaxArgs(MaxArgs)) i_dut (
    .clk_i, .rst_ni, .push, .full, .ch_i, .last_i, .empty, .pop,
    .kind_o, .spec_type_o, .upper_case_o, .arg_index_o, .flag_bits_o,
    .field_width_o, .precision_value_o, .has_precision_o, .literal_length_o,
    .error_code_o, .end_of_run_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  fst_pkg::phase_e ph;
  logic [7:0]  idx_acc;
  logic [2:0]  flag_st;
  logic [7:0]  wid_st;
  logic [8:0]  prec_st;
  logic [2:0]  marks;
  logic [4:0]  idx_cnt;
  logic [15:0] used_map;
  logic [11:0] run_len;
  logic [7:0]  float_prec = fst_pkg::DefaultFloatPrec;

  localparam logic [8:0] PrecNone = 9'd256;
  localparam logic [2:0] MarkPos = 3'd1;
  localparam logic [2:0] MarkSeq = 3'd2;
  localparam logic [2:0] MarkWidNum = 3'd4;

  fst_pkg::token_t step_toks[$];
  fst_pkg::token_t expected_tokens[$];
  int     err_cnt = 0;
  int     send_idle = 0;
  int     rcv_stall = 0;
  longint cycles = 0;

  function automatic logic [7:0] dec_accum(input logic [7:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(fst_pkg::ChZero);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic fst_pkg::token_t err_tok(input fst_pkg::err_e code);
    fst_pkg::token_t t;
    t = '0;
    t.kind = fst_pkg::K_ERR;
    t.error_code = code;
    t.end_of_run = 1'b1;
    return t;
  endfunction

  task automatic emit(input fst_pkg::kind_e k, input fst_pkg::spec_e ty, input logic up,
                      input int idx, input logic [2:0] fl, input logic [7:0] w,
                      input logic [7:0] p, input logic hp, input logic [11:0] len,
                      input fst_pkg::err_e code);
    fst_pkg::token_t t;
    t = '0;
    t.kind = k;
    t.spec_type = ty;
    t.upper_case = up;
    t.arg_index = idx[4:0];
    t.flag_bits = fl;
    t.field_width = w;
    t.precision_value = p;
    t.has_precision = hp;
    t.literal_length = len;
    t.error_code = (k == fst_pkg::K_ERR) ? code : 4'd0;
    if (step_toks.size() < 2) step_toks.push_back(t);
  endtask

  task automatic raise_err(input fst_pkg::err_e code, input int idx);
    emit(fst_pkg::K_ERR, fst_pkg::T_STR, 1'b0, idx, 3'd0, 8'd0, 8'd0, 1'b0, 12'd0, code);
    ph = fst_pkg::PH_DEAD;
  endtask

  task automatic accept_spec(input fst_pkg::spec_e ty, input logic up,
                             input logic [2:0] fl, input logic [7:0] w,
                             input logic [7:0] p, input logic hp);
    int idx;
    idx = idx_acc;
    if (idx == 0 || idx > MaxArgs) begin
      raise_err(fst_pkg::E_IDX_BIG, 0);
      return;
    end
    if (idx > idx_cnt) idx_cnt = idx[4:0];
    if (used_map[idx-1]) begin
      raise_err(fst_pkg::E_DUP_IDX, idx);
      return;
    end
    used_map[idx-1] = 1'b1;
    emit(fst_pkg::K_SPEC, ty, up, idx, fl, w, p, hp, 12'd0, fst_pkg::E_REP_FLAG);
    ph = fst_pkg::PH_LIT;
    run_len = '0;
  endtask

  task automatic type_char(input logic [7:0] c);
    logic       given;
    logic [7:0] pv;
    given = (prec_st != PrecNone);
    pv = given ? prec_st[7:0] : 8'd0;
    case (c)
      "s": accept_spec(fst_pkg::T_STR, 1'b0, flag_st, wid_st, pv, given);
      "b": accept_spec(fst_pkg::T_BOOL, 1'b0, flag_st, wid_st, pv, given);
      "f": accept_spec(fst_pkg::T_FLOAT, 1'b0, flag_st, wid_st, given ? pv : float_prec,
                       1'b1);
      "c": begin
        if (flag_st != 0 || wid_st != 0 || given) raise_err(fst_pkg::E_CHAR_EXTRA, 0);
        else accept_spec(fst_pkg::T_CHAR, 1'b0, 3'd0, 8'd0, 8'd0, 1'b0);
      end
      "l", "i", "d", "u": begin
        if (given) raise_err(fst_pkg::E_PREC_INT, 0);
        else if (c == "l") ph = fst_pkg::PH_LLOOP;
        else accept_spec((c == "u") ? fst_pkg::T_UNSIGNED : fst_pkg::T_SIGNED, 1'b0,
                         flag_st, wid_st, 8'd0, 1'b0);
      end
      "x", fst_pkg::ChUpX: begin
        if (given) raise_err(fst_pkg::E_PREC_INT, 0);
        else accept_spec(fst_pkg::T_HEX, c == fst_pkg::ChUpX, flag_st, wid_st, 8'd0, 1'b0);
      end
      "p", fst_pkg::ChUpP: begin
        if (given) raise_err(fst_pkg::E_PREC_INT, 0);
        else accept_spec(fst_pkg::T_PTR, c == fst_pkg::ChUpP, flag_st, wid_st, 8'd0, 1'b0);
      end
      default: raise_err(fst_pkg::E_BAD_TYPE, 0);
    endcase
  endtask

  task automatic type_sel(input logic [7:0] c);
    if (c == fst_pkg::ChDot) ph = fst_pkg::PH_DOT;
    else type_char(c);
  endtask

  task automatic flags_char(input logic [7:0] c);
    logic [2:0] f;
    f = (c == fst_pkg::ChPlus) ? 3'd1 : (c == fst_pkg::ChMinus) ? 3'd2 :
        (c == fst_pkg::ChZero) ? 3'd4 : 3'd0;
    if (f != 0) begin
      if ((flag_st & f) != 0) raise_err(fst_pkg::E_REP_FLAG, 0);
      else flag_st |= f;
    end else if (c >= fst_pkg::ChZero && c <= fst_pkg::ChNine) begin
      wid_st = c - fst_pkg::ChZero;
      ph = fst_pkg::PH_WID;
    end else begin
      type_sel(c);
    end
  endtask

  task automatic fresh_string();
    ph = fst_pkg::PH_LIT;
    idx_acc = '0;
    flag_st = '0;
    wid_st = '0;
    prec_st = PrecNone;
    marks = '0;
    idx_cnt = '0;
    used_map = '0;
    run_len = '0;
  endtask

  task automatic close_string();
    if (ph == fst_pkg::PH_DEAD) return;
    case (ph)
      fst_pkg::PH_LIT: ;
      fst_pkg::PH_DOT: begin raise_err(fst_pkg::E_NO_PREC, 0); return; end
      fst_pkg::PH_PREC: begin raise_err(fst_pkg::E_BAD_TYPE, 0); return; end
      fst_pkg::PH_LLOOP: begin raise_err(fst_pkg::E_BAD_L, 0); return; end
      default: begin raise_err(fst_pkg::E_UNTERM, 0); return; end
    endcase
    if (run_len > 0)
      emit(fst_pkg::K_LIT, fst_pkg::T_STR, 1'b0, 0, 3'd0, 8'd0, 8'd0, 1'b0, run_len,
           fst_pkg::E_REP_FLAG);
    for (int i = 0; i < idx_cnt; i++) begin
      if (!used_map[i]) begin
        raise_err(fst_pkg::E_UNUSED, i + 1);
        return;
      end
    end
    emit(fst_pkg::K_DONE, fst_pkg::T_STR, 1'b0, idx_cnt, 3'd0, 8'd0, 8'd0, 1'b0, 12'd0,
         fst_pkg::E_REP_FLAG);
  endtask

  // Computes the tokens one character causes into step_toks.
  task automatic tokenize_char(input logic [7:0] c, input logic lst);
    step_toks.delete();
    case (ph)
      fst_pkg::PH_LIT: begin
        if (c == fst_pkg::ChPct) begin
          if (run_len > 0)
            emit(fst_pkg::K_LIT, fst_pkg::T_STR, 1'b0, 0, 3'd0, 8'd0, 8'd0, 1'b0, run_len,
                 fst_pkg::E_REP_FLAG);
          run_len = '0;
          ph = fst_pkg::PH_PCT;
        end else if (run_len < 12'd4095) begin
          run_len++;
        end
      end
      fst_pkg::PH_PCT: begin
        if (c == fst_pkg::ChPct) begin
          emit(fst_pkg::K_PCT, fst_pkg::T_STR, 1'b0, 0, 3'd0, 8'd0, 8'd0, 1'b0, 12'd0,
               fst_pkg::E_REP_FLAG);
          ph = fst_pkg::PH_LIT;
        end else begin
          flag_st = '0;
          wid_st = '0;
          prec_st = PrecNone;
          marks &= ~MarkWidNum;
          if (c >= fst_pkg::ChOne && c <= fst_pkg::ChNine) begin
            idx_acc = c - fst_pkg::ChZero;
            ph = fst_pkg::PH_IDX;
          end else if (marks & MarkPos) begin
            raise_err(fst_pkg::E_MIXED, 0);
          end else begin
            marks |= MarkSeq;
            idx_acc = idx_cnt + 8'd1;
            ph = fst_pkg::PH_FLAGS;
            flags_char(c);
          end
        end
      end
      fst_pkg::PH_IDX: begin
        if (c >= fst_pkg::ChZero && c <= fst_pkg::ChNine) begin
          idx_acc = dec_accum(idx_acc, c);
        end else if (c == fst_pkg::ChPct || c == fst_pkg::ChDollar) begin
          if (marks & MarkSeq) raise_err(fst_pkg::E_MIXED, 0);
          else begin
            marks |= MarkPos;
            if (c == fst_pkg::ChPct)
              accept_spec(fst_pkg::T_WILD, 1'b0, 3'd0, 8'd0, 8'd0, 1'b0);
            else ph = fst_pkg::PH_FLAGS;
          end
        end else if (marks & MarkPos) begin
          raise_err(fst_pkg::E_MIXED, 0);
        end else begin
          marks |= MarkSeq | MarkWidNum;
          wid_st = idx_acc;
          idx_acc = idx_cnt + 8'd1;
          type_sel(c);
        end
      end
      fst_pkg::PH_FLAGS: flags_char(c);
      fst_pkg::PH_WID: begin
        if (c >= fst_pkg::ChZero && c <= fst_pkg::ChNine) wid_st = dec_accum(wid_st, c);
        else type_sel(c);
      end
      fst_pkg::PH_DOT: begin
        if (c >= fst_pkg::ChZero && c <= fst_pkg::ChNine) begin
          prec_st = {1'b0, c - fst_pkg::ChZero};
          ph = fst_pkg::PH_PREC;
        end else raise_err(fst_pkg::E_NO_PREC, 0);
      end
      fst_pkg::PH_PREC: begin
        if (c >= fst_pkg::ChZero && c <= fst_pkg::ChNine)
          prec_st = {1'b0, dec_accum(prec_st[7:0], c)};
        else type_char(c);
      end
      fst_pkg::PH_LLOOP: begin
        if (c == "d" || c == "i")
          accept_spec(fst_pkg::T_SIGNED, 1'b0, flag_st, wid_st, 8'd0, 1'b0);
        else if (c == "u")
          accept_spec(fst_pkg::T_UNSIGNED, 1'b0, flag_st, wid_st, 8'd0, 1'b0);
        else if (c != "l") raise_err(fst_pkg::E_BAD_L, 0);
      end
      default: ph = fst_pkg::PH_DEAD;
    endcase
    if (lst) begin
      close_string();
      fresh_string();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].end_of_run = 1'b1;
  endtask

  // Called right after a rising edge; returns right after the edge of the transfer.
  task automatic send_char(input logic [7:0] c, input logic lst, input logic typed = 1'b0,
                           input fst_pkg::token_t tok = '0);
    logic ok;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    last_i <= lst;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
    tokenize_char(c, lst);
    if (typed) expected_tokens.push_back(tok);
    else foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_float_prec(input logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    float_prec = v;
    @(posedge clk_i);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) pop <= ($urandom_range(99) >= rcv_stall);

  always @(negedge clk_i) begin
    fst_pkg::token_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_tokens.size() == 0) begin
        report("unexpected token, kind", kind_o, -1);
      end else begin
        e = expected_tokens.pop_front();
        if (kind_o != e.kind) report("kind", kind_o, e.kind);
        if (spec_type_o != e.spec_type) report("spec_type", spec_type_o, e.spec_type);
        if (upper_case_o != e.upper_case) report("upper_case", upper_case_o, e.upper_case);
        if (arg_index_o != e.arg_index) report("arg_index", arg_index_o, e.arg_index);
        if (flag_bits_o != e.flag_bits) report("flag_bits", flag_bits_o, e.flag_bits);
        if (field_width_o != e.field_width)
          report("field_width", field_width_o, e.field_width);
        if (precision_value_o != e.precision_value)
          report("precision_value", precision_value_o, e.precision_value);
        if (has_precision_o != e.has_precision)
          report("has_precision", has_precision_o, e.has_precision);
        if (literal_length_o != e.literal_length)
          report("literal_length", literal_length_o, e.literal_length);
        if (error_code_o != e.error_code) report("error_code", error_code_o, e.error_code);
        if (end_of_run_o != e.end_of_run) report("end_of_run", end_of_run_o, e.end_of_run);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    logic [7:0]      c;
    logic            lst;
    logic            typed;
    fst_pkg::token_t tok;
  } stim_row_t;

  task automatic add_num(ref logic [7:0] s[$], input int v);
    string d;
    d = $sformatf("%0d", v);
    for (int i = 0; i < d.len(); i++) s.push_back(d[i]);
  endtask

  // One random format string, mostly well formed.
  task automatic build_string(ref logic [7:0] s[$]);
    logic     positional;
    int       next_idx;
    int       r;
    string    types;
    s.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(9);
        s.push_back(r < 3 ? fst_pkg::ChPct
                    : r < 6 ? 8'($urandom_range(fst_pkg::ChZero, fst_pkg::ChNine))
                    : 8'($urandom_range(255)));
      end
      return;
    end
    types = "sbfcdiuxXpPl";
    positional = $urandom_range(1);
    next_idx = 1;
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(99);
      if (r < 25) begin
        repeat ($urandom_range(1, 6)) begin
          s.push_back(8'($urandom_range(255)));
          if (s[s.size()-1] == fst_pkg::ChPct) s[s.size()-1] = "a";
        end
      end else if (r < 32) begin
        s.push_back(fst_pkg::ChPct);
        s.push_back(fst_pkg::ChPct);
      end else begin
        s.push_back(fst_pkg::ChPct);
        if (positional) begin
          add_num(s, $urandom_range(99) < 8 ? $urandom_range(0, 300) : next_idx);
          next_idx += ($urandom_range(99) < 10) ? 2 : 1;
          if ($urandom_range(99) < 15) begin
            s.push_back(fst_pkg::ChPct);
            continue;
          end
          s.push_back(fst_pkg::ChDollar);
        end
        if ($urandom_range(99) < 30) s.push_back(fst_pkg::ChPlus);
        if ($urandom_range(99) < 30) s.push_back(fst_pkg::ChMinus);
        if ($urandom_range(99) < 30) s.push_back(fst_pkg::ChZero);
        if ($urandom_range(99) < 4) s.push_back(fst_pkg::ChPlus);
        if ($urandom_range(99) < 40)
          add_num(s, $urandom_range(99) < 10 ? $urandom_range(256, 9999)
                     : $urandom_range(1, 40));
        if ($urandom_range(99) < 30) begin
          s.push_back(fst_pkg::ChDot);
          if ($urandom_range(99) < 95)
            add_num(s, $urandom_range(99) < 10 ? $urandom_range(0, 999) : $urandom_range(9));
        end
        if ($urandom_range(99) < 4) s.push_back(8'($urandom_range(255)));
        else begin
          r = $urandom_range(types.len() - 1);
          s.push_back(types[r]);
          if (types[r] == "l") begin
            if ($urandom_range(1)) s.push_back("l");
            r = $urandom_range(9);
            s.push_back(r < 4 ? "d" : r < 6 ? "i" : r < 9 ? "u" : "q");
          end
        end
      end
    end
    if (s.size() == 0) s.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    stim_row_t   rows[$];
    logic [7:0]  str[$];
    int          sent;
    logic [7:0]  cfg_vals[4];

    fresh_string();
    rows = '{
      '{"a", 1'b0, 1'b0, '0}, '{fst_pkg::ChPct, 1'b0, 1'b0, '0},
      '{fst_pkg::ChPct, 1'b0, 1'b0, '0}, '{fst_pkg::ChPct, 1'b0, 1'b0, '0},
      '{fst_pkg::ChPlus, 1'b0, 1'b0, '0}, '{fst_pkg::ChMinus, 1'b0, 1'b0, '0},
      '{fst_pkg::ChZero, 1'b0, 1'b0, '0}, '{"8", 1'b0, 1'b0, '0},
      '{fst_pkg::ChDot, 1'b0, 1'b0, '0}, '{"3", 1'b0, 1'b0, '0}, '{"f", 1'b0, 1'b0, '0},
      '{fst_pkg::ChPct, 1'b0, 1'b0, '0}, '{fst_pkg::ChUpX, 1'b0, 1'b0, '0},
      '{"Z", 1'b1, 1'b0, '0},
      '{fst_pkg::ChPct, 1'b0, 1'b0, '0}, '{fst_pkg::ChPlus, 1'b0, 1'b0, '0},
      '{fst_pkg::ChPlus, 1'b0, 1'b1, err_tok(fst_pkg::E_REP_FLAG)},
      '{"q", 1'b1, 1'b0, '0},
      '{fst_pkg::ChPct, 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0},
      '{fst_pkg::ChDollar, 1'b0, 1'b0, '0},
      '{"d", 1'b0, 1'b1, err_tok(fst_pkg::E_IDX_BIG)},
      '{8'h00, 1'b1, 1'b0, '0},
      '{fst_pkg::ChPct, 1'b0, 1'b0, '0},
      '{8'hff, 1'b1, 1'b1, err_tok(fst_pkg::E_BAD_TYPE)}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_char(rows[i].c, rows[i].lst, rows[i].typed, rows[i].tok);

    cfg_vals = '{8'd0, 8'd255, 8'($urandom_range(255)), fst_pkg::DefaultFloatPrec};
    for (int p = 0; p < 4; p++) begin
      write_float_prec(cfg_vals[p]);
      send_idle = (p == 1 || p == 3) ? 84 : 0;
      rcv_stall = (p >= 2) ? 84 : 0;
      if (p == 3) begin
        send_idle = 9;
        rcv_stall = 9;
      end
      sent = 0;
      while (sent < 470) begin
        build_string(str);
        foreach (str[i]) send_char(str[i], i == str.size() - 1);
        sent += str.size();
        if (p == 1 && sent > 200 && sent < 230) drain();
      end
    end

    push <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
